FILE: rtl/order_statistic_set_top_defines.svh
// assertion macros shared by the order statistic set rtl
`ifndef ORDER_STATISTIC_SET_TOP_DEFINES_SVH
`define ORDER_STATISTIC_SET_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("order statistic set check failed");
`define OST_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("order statistic set sequence check failed");
`else
`define OST_ASSERT(name, prop)
`define OST_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: rtl/ost_pkg.sv
// shared types and constants of the order statistic set
`timescale 1ns / 1ps
`default_nettype none
package ost_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RANK_W   = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_CONTAINS = 2'd1,
    CMD_SELECT   = 2'd2,
    CMD_RANK     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_DUP   = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request, open search window
    logic sel_read;    // read entry k-1
    logic probe;       // read midpoint of search window
    logic step;        // narrow search window
    logic fetch;       // read entry at lower bound
    logic check;       // latch presence and fullness
    logic shift_init;  // start moving the tail up
    logic shift_step;  // move one entry up
    logic write_new;   // store new value, bump count
    logic load_rsp;    // load response register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_select;
    logic search_done;
    logic insert_go;
    logic need_shift;
    logic shift_last;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ost_req_if.sv
// request channel of the order statistic set
`timescale 1ns / 1ps
`default_nettype none
interface ost_req_if;
  import ost_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface
`default_nettype wire

FILE: rtl/ost_rsp_if.sv
// response channel of the order statistic set
`timescale 1ns / 1ps
`default_nettype none
interface ost_rsp_if;
  import ost_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic                    found;
  logic signed [VAL_W-1:0] value;
  logic [RANK_W-1:0]       rank;

  modport source (output valid, output status, output found, output value, output rank,
                  input ready);
  modport sink   (input valid, input status, input found, input value, input rank,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/order_statistic_set_top.sv
// top level of the order statistic set: bounded sorted store with rank and select
//
//  channel  dir  handshake       payload
//  req_i    in   valid / ready   cmd[1:0], operand[31:0] signed
//  rsp_o    out  valid / ready   status[1:0], found, value[31:0] signed, rank[8:0]
//
// select reads entry k-1 and goes straight to the response; contains and rank
// alternate probe and step for each of s binary search steps over the single read port of
// the value store, at most ceil(log2(n+1)) for n stored values, then fetch and check;
// insert adds one shift step per entry moved up and one write. One request is in flight at a time.
// reset empties the store at once (count to zero), no clearing pass.
// a response waiting in the output register lets the next request in, which then
// waits in its response state until the waiting response is taken.
`timescale 1ns / 1ps
`default_nettype none
module order_statistic_set_top #(
  parameter int unsigned CAPACITY = 256
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ost_req_if.sink   req_i,
  ost_rsp_if.source rsp_o
);
  import ost_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  ost_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  ost_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .in_cmd_i     (req_i.cmd),
    .in_operand_i (req_i.operand),
    .status_o     (rsp_o.status),
    .found_o      (rsp_o.found),
    .value_o      (rsp_o.value),
    .rank_o       (rsp_o.rank)
  );

endmodule
`default_nettype wire

FILE: rtl/ost_ctrl.sv
// sequencing state machine of the order statistic set
`timescale 1ns / 1ps
`default_nettype none
module ost_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ost_pkg::dp_cmd_t      cmd_o,
  input  wire ost_pkg::dp_sts_t sts_i
);
  import ost_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_CMP    = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_SHIFT  = 7'b0010000,
    ST_WRITE  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.is_select) begin
          cmd.sel_read = 1'b1;
          state_d      = ST_RESP;
        end else if (!sts_i.search_done) begin
          cmd.probe = 1'b1;
          state_d   = ST_CMP;
        end else begin
          cmd.fetch = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CMP: begin
        cmd.step = 1'b1;
        state_d  = ST_SEARCH;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts_i.insert_go) begin
          if (sts_i.need_shift) begin
            cmd.shift_init = 1'b1;
            state_d        = ST_SHIFT;
          end else begin
            state_d = ST_WRITE;
          end
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts_i.shift_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_new = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_rsp = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and response valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule
`default_nettype wire

FILE: rtl/ost_dp.sv
// sorted value store, binary search and response datapath
`timescale 1ns / 1ps
`default_nettype none
`include "order_statistic_set_top_defines.svh"
module ost_dp #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ost_pkg::dp_cmd_t                 cmd_i,
  output ost_pkg::dp_sts_t                      sts_o,
  input  wire logic [ost_pkg::CMD_W-1:0]        in_cmd_i,
  input  wire logic signed [ost_pkg::VAL_W-1:0] in_operand_i,
  output logic [ost_pkg::STATUS_W-1:0]          status_o,
  output logic                                  found_o,
  output logic signed [ost_pkg::VAL_W-1:0]      value_o,
  output logic [ost_pkg::RANK_W-1:0]            rank_o
);
  import ost_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic signed [VAL_W-1:0] mem [CAPACITY];

  logic [CW-1:0]           cnt_q;
  cmd_e                    cmd_q;
  logic signed [VAL_W-1:0] op_q;
  logic [CW-1:0]           lo_q, hi_q, mid_q, j_q;
  logic signed [VAL_W-1:0] rd_q;
  logic                    present_q, full_q;
  logic [STATUS_W-1:0]     status_q;
  logic                    found_q;
  logic signed [VAL_W-1:0] value_q;
  logic [RANK_W-1:0]       rank_q;

  logic [CW-1:0]           mid_c;
  logic                    sel_ok, present_c, full_c, less_c;
  logic                    re, we;
  logic [AW-1:0]           ra, wa;
  logic signed [VAL_W-1:0] wd;

  // comparisons and search midpoint
  assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
  assign less_c    = (rd_q < op_q);
  assign full_c    = (cnt_q == CW'(CAPACITY));
  assign present_c = (lo_q < cnt_q) && (rd_q == op_q);
  assign sel_ok    = !op_q[VAL_W-1] && (op_q != '0) &&
                     ($unsigned(op_q) <= VAL_W'(cnt_q));

  // status to controller
  always_comb begin
    sts_o             = '0;
    sts_o.is_select   = (cmd_q == CMD_SELECT);
    sts_o.search_done = (lo_q >= hi_q);
    sts_o.insert_go   = (cmd_q == CMD_INSERT) && !present_c && !full_c;
    sts_o.need_shift  = (cnt_q != lo_q);
    sts_o.shift_last  = (j_q == lo_q + CW'(1));
  end

  // memory read port select
  always_comb begin
    re = 1'b0;
    ra = '0;
    priority if (cmd_i.sel_read) begin
      re = sel_ok;
      ra = AW'($unsigned(op_q) - VAL_W'(1));
    end else if (cmd_i.probe) begin
      re = 1'b1;
      ra = mid_c[AW-1:0];
    end else if (cmd_i.fetch) begin
      re = (lo_q < cnt_q);
      ra = lo_q[AW-1:0];
    end else if (cmd_i.shift_init) begin
      re = 1'b1;
      ra = AW'(cnt_q - CW'(1));
    end else if (cmd_i.shift_step) begin
      re = !sts_o.shift_last;
      ra = AW'(j_q - CW'(2));
    end
  end

  // memory write port select
  always_comb begin
    we = cmd_i.shift_step || cmd_i.write_new;
    wa = cmd_i.write_new ? lo_q[AW-1:0] : j_q[AW-1:0];
    wd = cmd_i.write_new ? op_q : rd_q;
  end

  // value store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.write_new) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // request capture, search window, presence and fullness flags and shift pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(in_cmd_i);
      op_q  <= in_operand_i;
      lo_q  <= '0;
      hi_q  <= cnt_q;
    end
    if (cmd_i.probe) begin
      mid_q <= mid_c;
    end
    if (cmd_i.step) begin
      if (less_c) begin
        lo_q <= mid_q + CW'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.check) begin
      present_q <= present_c;
      full_q    <= full_c;
    end
    if (cmd_i.shift_init) begin
      j_q <= cnt_q;
    end else if (cmd_i.shift_step) begin
      j_q <= j_q - CW'(1);
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      status_q <= STS_OK;
      found_q  <= 1'b0;
      value_q  <= '0;
      rank_q   <= '0;
      unique case (cmd_q)
        CMD_INSERT: begin
          found_q <= present_q;
          if (present_q) begin
            status_q <= STS_DUP;
          end else if (full_q) begin
            status_q <= STS_FULL;
          end
        end
        CMD_CONTAINS: begin
          found_q <= present_q;
        end
        CMD_SELECT: begin
          if (sel_ok) begin
            value_q <= rd_q;
          end else begin
            status_q <= STS_RANGE;
          end
        end
        CMD_RANK: begin
          found_q <= present_q;
          rank_q  <= RANK_W'(lo_q);
        end
        default: begin
          status_q <= STS_OK;
        end
      endcase
    end
  end

  assign status_o = status_q;
  assign found_o  = found_q;
  assign value_o  = value_q;
  assign rank_o   = rank_q;

  // checks
  `OST_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY))
  `OST_ASSERT_NEXT(a_cnt_only_on_write, !cmd_i.write_new, $stable(cnt_q))
  `OST_ASSERT(a_no_write_when_full, !cmd_i.write_new || (cnt_q < CW'(CAPACITY)))
  `OST_ASSERT(a_probe_window_open, !cmd_i.probe || (lo_q < hi_q))

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench of the order statistic set: predicted responses vs. the block
`timescale 1ns / 1ps
module testbench;
  import ost_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 400;

  localparam logic signed [VAL_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

  typedef struct {
    status_e                 status;
    logic                    found;
    logic signed [VAL_W-1:0] value;
    logic [RANK_W-1:0]       rank;
  } set_result_t;

  logic clk_i;
  logic rst_ni;

  ost_req_if req_bus ();
  ost_rsp_if rsp_bus ();

  order_statistic_set_top #(
    .CAPACITY(STORE_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // predicted contents of the set, ascending signed order
  logic signed [VAL_W-1:0] set_members[$];
  set_result_t             pending_responses[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_enable = 1'b1;
  int unsigned rsp_hold_left = 0;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** order_statistic_set_top: FAILED **");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_enable) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // apply one command to the predicted set and return its response
  function automatic set_result_t apply_to_set(cmd_e op, logic signed [VAL_W-1:0] opnd);
    set_result_t rsp;
    int          pos;
    bit          present;
    rsp.status = STS_OK;
    rsp.found  = 1'b0;
    rsp.value  = '0;
    rsp.rank   = '0;
    if (op == CMD_SELECT) begin
      if (opnd < 1 || opnd > set_members.size()) begin
        rsp.status = STS_RANGE;
      end else begin
        rsp.value = set_members[opnd - 1];
      end
    end else begin
      pos = 0;
      while (pos < set_members.size() && set_members[pos] < opnd) begin
        pos++;
      end
      present   = (pos < set_members.size()) && (set_members[pos] == opnd);
      rsp.found = present;
      case (op)
        CMD_INSERT: begin
          if (present) begin
            rsp.status = STS_DUP;
          end else if (set_members.size() >= STORE_DEPTH) begin
            rsp.status = STS_FULL;
          end else begin
            set_members.insert(pos, opnd);
          end
        end
        CMD_RANK: begin
          rsp.rank = pos[RANK_W-1:0];
        end
        default: begin
        end
      endcase
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got_bits,
                                 logic [VAL_W-1:0] exp_bits);
    error_count++;
    $display("[%0t] mismatch %s: got 0x%08h, expected 0x%08h", $time, what, got_bits,
             exp_bits);
  endtask

  // response checker
  always @(posedge clk_i) begin : check_responses
    set_result_t exp_rsp;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response with no request pending", rsp_bus.value, '0);
      end else begin
        exp_rsp = pending_responses.pop_front();
        if (rsp_bus.status !== exp_rsp.status) begin
          report_mismatch("status", VAL_W'(rsp_bus.status), VAL_W'(exp_rsp.status));
        end
        if (rsp_bus.found !== exp_rsp.found) begin
          report_mismatch("found", VAL_W'(rsp_bus.found), VAL_W'(exp_rsp.found));
        end
        if (rsp_bus.value !== exp_rsp.value) begin
          report_mismatch("value", rsp_bus.value, exp_rsp.value);
        end
        if (rsp_bus.rank !== exp_rsp.rank) begin
          report_mismatch("rank", VAL_W'(rsp_bus.rank), VAL_W'(exp_rsp.rank));
        end
      end
    end
  end

  // response ready: a long hold-off while rsp_hold_left runs down, else random stalls
  initial begin : drive_rsp_ready
    int unsigned stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_left > 0) begin
        rsp_bus.ready = 1'b0;
        rsp_hold_left--;
      end else if (stall_left > 0) begin
        rsp_bus.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready = rst_ni;
        stall_left = pick_gap();
      end
    end
  end

  // offer one request and wait until it is taken
  task automatic send_request(cmd_e op, logic signed [VAL_W-1:0] opnd);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid   = 1'b1;
    req_bus.cmd     = op;
    req_bus.operand = opnd;
    do begin
      @(posedge clk_i);
    end while (!req_bus.ready);
    pending_responses.push_back(apply_to_set(op, opnd));
  endtask

  // stop offering and wait until every response is back
  task automatic drain_responses();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (pending_responses.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // operand for value commands: members, their neighbors, a small window, anything, extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && set_members.size() > 0) begin
      return set_members[$urandom_range(0, set_members.size() - 1)] +
             ($signed($urandom_range(0, 2)) - 1);
    end else if (roll < 7) begin
      return $signed($urandom_range(0, 80)) - 40;
    end else if (roll < 9) begin
      return $urandom;
    end
    case ($urandom_range(0, 5))
      0: return MOST_NEGATIVE;
      1: return MOST_POSITIVE;
      2: return MOST_NEGATIVE + 1;
      3: return MOST_POSITIVE - 1;
      4: return -1;
      default: return 0;
    endcase
  endfunction

  // k for select: mostly in range, sometimes just outside or wild
  function automatic logic signed [VAL_W-1:0] pick_k();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7 && set_members.size() > 0) begin
      return $urandom_range(1, set_members.size());
    end else if (roll == 7) begin
      return 0;
    end else if (roll == 8) begin
      return set_members.size() + 1;
    end
    return $urandom;
  endfunction

  task automatic send_random_request();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      send_request(CMD_INSERT, pick_value());
    end else if (roll < 52) begin
      send_request(CMD_CONTAINS, pick_value());
    end else if (roll < 76) begin
      send_request(CMD_SELECT, pick_k());
    end else begin
      send_request(CMD_RANK, pick_value());
    end
  endtask

  // queries on an empty store
  task automatic test_empty_store();
    send_request(CMD_SELECT, 1);
    send_request(CMD_RANK, 0);
    send_request(CMD_CONTAINS, 0);
    drain_responses();
  endtask

  // extreme values, duplicates and select out of range
  task automatic test_extremes();
    send_request(CMD_INSERT, MOST_NEGATIVE);
    send_request(CMD_INSERT, MOST_POSITIVE);
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, -1);
    send_request(CMD_INSERT, MOST_POSITIVE);
    send_request(CMD_CONTAINS, MOST_NEGATIVE);
    send_request(CMD_CONTAINS, 12345);
    send_request(CMD_RANK, MOST_POSITIVE);
    send_request(CMD_RANK, MOST_NEGATIVE);
    send_request(CMD_RANK, 12345);
    send_request(CMD_SELECT, 1);
    send_request(CMD_SELECT, 4);
    send_request(CMD_SELECT, 5);
    send_request(CMD_SELECT, 0);
    send_request(CMD_SELECT, -1);
    send_request(CMD_SELECT, MOST_NEGATIVE);
    send_request(CMD_SELECT, MOST_POSITIVE);
    drain_responses();
  endtask

  task automatic test_random_traffic(int unsigned count, bit with_idle);
    idle_enable = with_idle;
    repeat (count) send_random_request();
    drain_responses();
    idle_enable = 1'b1;
  endtask

  // response side held off while requests keep coming
  task automatic test_backpressure();
    idle_enable = 1'b0;
    @(posedge clk_i);
    rsp_hold_left = 200;
    repeat (16) send_random_request();
    drain_responses();
    idle_enable = 1'b1;
  endtask

  // insert fresh values until the store is full
  task automatic test_fill_to_capacity();
    while (set_members.size() < STORE_DEPTH) begin
      send_request(CMD_INSERT, $urandom);
    end
    drain_responses();
  endtask

  // full store: new value dropped, present value still a duplicate
  task automatic test_full_store();
    send_request(CMD_INSERT, MOST_NEGATIVE + 7);
    send_request(CMD_INSERT, MOST_POSITIVE);
    send_request(CMD_RANK, MOST_POSITIVE);
    send_request(CMD_RANK, MOST_POSITIVE - 1);
    send_request(CMD_SELECT, STORE_DEPTH);
    send_request(CMD_SELECT, STORE_DEPTH + 1);
    drain_responses();
  endtask

  // test sequence
  initial begin
    rst_ni          = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.cmd     = CMD_INSERT;
    req_bus.operand = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_store();
    test_extremes();
    test_random_traffic(800, 1'b1);
    test_backpressure();
    test_random_traffic(200, 1'b0);
    test_fill_to_capacity();
    test_full_store();
    test_random_traffic(250, 1'b1);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** order_statistic_set_top: PASSED **");
    end else begin
      $display("** order_statistic_set_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ost_pkg.sv
rtl/ost_req_if.sv
rtl/ost_rsp_if.sv
rtl/ost_ctrl.sv
rtl/ost_dp.sv
rtl/order_statistic_set_top.sv
dv/testbench.sv
